### rtl/tgbo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgbo_pkg
// Shared constants, codes and beat types of the tile grid box overlap unit.
// ----------------------------------------------------------------------------
package tgbo_pkg;

    // grid limits and derived index widths
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ROW_BITS   = $clog2(MAX_HEIGHT);

    // coordinate format
    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS  = 4;
    localparam int RANGE_BITS = COORD_BITS + 1;
    localparam int TILE_BITS  = 16;

    // configuration register widths
    localparam int DIM_BITS      = 9;
    localparam int SHIFT_BITS    = 5;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 9;

    // tile_shift reset: a 16.0 unit tile
    localparam logic [SHIFT_BITS-1:0] TILE_SHIFT_RST = SHIFT_BITS'(4 + FRAC_BITS);

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TILE_SHIFT  = 2'd2;

    // command codes
    localparam logic [1:0] CMD_SET   = 2'd0;
    localparam logic [1:0] CMD_BOX   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // input beat
    typedef struct packed {
        logic [1:0]                    cmd;
        logic signed [TILE_BITS-1:0]   tile_x;
        logic signed [TILE_BITS-1:0]   tile_y;
        logic                          solid_value;
        logic signed [COORD_BITS-1:0]  box_min_x;
        logic signed [COORD_BITS-1:0]  box_min_y;
        logic signed [COORD_BITS-1:0]  box_max_x;
        logic signed [COORD_BITS-1:0]  box_max_y;
    } t_item;

    // result beat
    typedef struct packed {
        logic       hit;
        logic [1:0] done_cmd;
    } t_result;

endpackage

### rtl/tile_grid_box_overlap_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_grid_box_overlap_unit
// Tile map of solid bits with set, clear and box overlap query commands.
// ----------------------------------------------------------------------------
// Usage
//   A command beat on i_item is taken at a rising edge with start high and
//   busy low. Each command gives one result beat on o_result, shown for one
//   cycle with o_result_valid; the receiver cannot hold it off.
//   The map is a row memory (MAX_HEIGHT rows of MAX_WIDTH bits, one read
//   or write port, registered read) with a valid flag per row in flops.
//   States passed after the accept edge, busy high in each of them:
//     clear / unused command      S_PREP
//     set, outside the grid       S_PREP
//     set                         S_PREP, S_SET_WR (row read, row write back)
//     box, empty after clamping   S_PREP, S_CLAMP
//     box                         S_PREP, S_CLAMP, S_MASK, S_SCAN, which
//       tests one map row a cycle and stops at the first row with a hit
//   busy drops in the cycle the result is shown, so the next command can be
//   taken there. Config writes on i_cfg_* take effect at once and must only
//   come while busy is low.
//   Reset: empty map (all row flags cleared at once, no clearing pass),
//   grid 0 x 0, tile_shift 4 + FRAC_BITS.
// ----------------------------------------------------------------------------
module tile_grid_box_overlap_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  tgbo_pkg::t_item                    i_item,
    input  logic                               i_cfg_we,
    input  logic [tgbo_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [tgbo_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata,
    output logic                               o_result_valid,
    output tgbo_pkg::t_result                  o_result
);
    import tgbo_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_PREP   = 6'b000010,
        S_CLAMP  = 6'b000100,
        S_MASK   = 6'b001000,
        S_SCAN   = 6'b010000,
        S_SET_WR = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [DIM_BITS-1:0]   r_grid_width, r_grid_height;
    logic [SHIFT_BITS-1:0] r_tile_shift;
    logic [DIM_BITS-1:0]   eff_w, eff_h;

    // command and box range
    t_item                        r_item;
    logic signed [RANGE_BITS-1:0] r_x0, r_x1, r_y0, r_y1;
    logic [COL_BITS-1:0]          r_cx0, r_cx1;
    logic [ROW_BITS-1:0]          r_cy, r_cy1;
    logic [MAX_WIDTH-1:0]         r_mask;

    // map storage
    logic [MAX_WIDTH-1:0]  mem [MAX_HEIGHT];
    logic [MAX_HEIGHT-1:0] r_row_vld;
    logic [MAX_WIDTH-1:0]  r_rd_data;
    logic                  r_rd_vld;
    logic                  rd_en, wr_en, clr_all;
    logic [ROW_BITS-1:0]   rd_addr;
    logic [MAX_WIDTH-1:0]  wr_data;

    // result
    logic    r_res_valid, n_res_valid;
    t_result r_result, n_result;

    // item range helpers
    logic                         accept;
    logic                         set_in_grid;
    logic signed [RANGE_BITS-1:0] min_x_ext, min_y_ext, max_x_m1, max_y_m1;
    logic signed [RANGE_BITS-1:0] w_m1, h_m1, cx0, cx1, cy0, cy1;
    logic                         box_empty;
    logic                         row_hit;
    logic [COL_BITS-1:0]          set_col;
    logic [ROW_BITS-1:0]          set_row;
    logic [MAX_WIDTH-1:0]         ones;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);
    assign ones   = '1;

    // grid size limited to the map
    assign eff_w = (32'(r_grid_width) > MAX_WIDTH) ? DIM_BITS'(MAX_WIDTH) : r_grid_width;
    assign eff_h = (32'(r_grid_height) > MAX_HEIGHT) ? DIM_BITS'(MAX_HEIGHT) : r_grid_height;

    // set target tile
    assign set_col     = r_item.tile_x[COL_BITS-1:0];
    assign set_row     = r_item.tile_y[ROW_BITS-1:0];
    assign set_in_grid = !r_item.tile_x[TILE_BITS-1] && !r_item.tile_y[TILE_BITS-1]
                      && ({1'b0, r_item.tile_x} < (TILE_BITS+1)'(eff_w))
                      && ({1'b0, r_item.tile_y} < (TILE_BITS+1)'(eff_h));

    // box edges widened, max edge lowered by one lsb
    assign min_x_ext = {r_item.box_min_x[COORD_BITS-1], r_item.box_min_x};
    assign min_y_ext = {r_item.box_min_y[COORD_BITS-1], r_item.box_min_y};
    assign max_x_m1  = {r_item.box_max_x[COORD_BITS-1], r_item.box_max_x} - RANGE_BITS'(1);
    assign max_y_m1  = {r_item.box_max_y[COORD_BITS-1], r_item.box_max_y} - RANGE_BITS'(1);

    // clamp tile range to the grid
    assign w_m1 = RANGE_BITS'(eff_w) - RANGE_BITS'(1);
    assign h_m1 = RANGE_BITS'(eff_h) - RANGE_BITS'(1);
    assign cx0  = r_x0[RANGE_BITS-1] ? '0 : r_x0;
    assign cy0  = r_y0[RANGE_BITS-1] ? '0 : r_y0;
    assign cx1  = (r_x1 > w_m1) ? w_m1 : r_x1;
    assign cy1  = (r_y1 > h_m1) ? h_m1 : r_y1;
    assign box_empty = (eff_w == '0) || (eff_h == '0) || (r_x1 < r_x0) || (r_y1 < r_y0)
                    || (cx1 < cx0) || (cy1 < cy0);

    // row under test overlaps a solid tile
    assign row_hit = r_rd_vld && |(r_rd_data & r_mask);

    // written row: stored bits or empty, with one tile replaced
    always_comb begin
        wr_data          = r_rd_vld ? r_rd_data : '0;
        wr_data[set_col] = r_item.solid_value;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_res_valid = 1'b0;
        n_result    = r_result;
        rd_en       = 1'b0;
        rd_addr     = r_cy;
        wr_en       = 1'b0;
        clr_all     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_result.done_cmd = r_item.cmd;
                n_result.hit      = 1'b0;
                unique case (r_item.cmd)
                    CMD_SET: begin
                        if (set_in_grid) begin
                            rd_en   = 1'b1;
                            rd_addr = set_row;
                            n_state = S_SET_WR;
                        end else begin
                            n_res_valid = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end
                    CMD_BOX: begin
                        n_state = S_CLAMP;
                    end
                    CMD_CLEAR: begin
                        clr_all     = 1'b1;
                        n_res_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                    default: begin
                        n_res_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                endcase
            end
            S_CLAMP: begin
                if (box_empty) begin
                    n_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_MASK;
                end
            end
            S_MASK: begin
                rd_en   = 1'b1;
                rd_addr = r_cy;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (row_hit || (r_cy == r_cy1)) begin
                    n_result.hit = row_hit;
                    n_res_valid  = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_cy + 1'b1;
                end
            end
            S_SET_WR: begin
                wr_en       = 1'b1;
                n_res_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_res_valid   <= 1'b0;
            r_row_vld     <= '0;
            r_grid_width  <= '0;
            r_grid_height <= '0;
            r_tile_shift  <= TILE_SHIFT_RST;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
            if (clr_all) begin
                r_row_vld <= '0;
            end else if (wr_en) begin
                r_row_vld[set_row] <= 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_wdata[DIM_BITS-1:0];
                    CFG_GRID_HEIGHT: r_grid_height <= i_cfg_wdata[DIM_BITS-1:0];
                    CFG_TILE_SHIFT:  r_tile_shift  <= i_cfg_wdata[SHIFT_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    // command beat and range registers
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (accept) begin
            r_item <= i_item;
        end
        // tile range by floor shift
        if (r_state == S_PREP) begin
            r_x0 <= min_x_ext >>> r_tile_shift;
            r_y0 <= min_y_ext >>> r_tile_shift;
            r_x1 <= max_x_m1 >>> r_tile_shift;
            r_y1 <= max_y_m1 >>> r_tile_shift;
        end
        if (r_state == S_CLAMP) begin
            r_cx0 <= cx0[COL_BITS-1:0];
            r_cx1 <= cx1[COL_BITS-1:0];
            r_cy  <= cy0[ROW_BITS-1:0];
            r_cy1 <= cy1[ROW_BITS-1:0];
        end
        // column mask over the clamped range
        if (r_state == S_MASK) begin
            r_mask <= (ones << r_cx0) & (ones >> (COL_BITS'(MAX_WIDTH - 1) - r_cx1));
        end
        if (r_state == S_SCAN) begin
            r_cy <= r_cy + 1'b1;
        end
    end

    // map row memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[set_row] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
            r_rd_vld  <= r_row_vld[rd_addr];
        end
    end

    assign o_result_valid = r_res_valid;
    assign o_result       = r_result;

endmodule

### rtl/tgbo_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgbo_checker
// Port level checks of the tile grid box overlap unit, bound to the top.
// ----------------------------------------------------------------------------
module tgbo_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_result_valid,
    input tgbo_pkg::t_result o_result
);
    import tgbo_pkg::*;

    // a taken command keeps the unit busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after a command beat");

    // a result beat is shown only once the unit is free again
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result beat while busy");

    // every finished command gives a result beat
    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_result_valid)
        else $error("command finished without a result beat");

    // one result beat per command, never two in a row
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result beat repeated");

    // only box queries can report a hit
    a_hit_box_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.done_cmd != CMD_BOX)) |-> !o_result.hit)
        else $error("hit on a command other than a box query");

endmodule

bind tile_grid_box_overlap_unit tgbo_checker u_tgbo_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);
